// File: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bprl_pkg.sv
// Package: widths, codes and types of the bounded positional record list
package bprl_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int MAX_REC   = 16;
   localparam int CNT_W     = 5;
   localparam int CAP_W     = 5;
   localparam int POS_W     = 5;
   localparam int CMD_W     = 3;
   localparam int ST_W      = 2;
   localparam int TAG_W     = 32;
   localparam int GRADE_W   = 10;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register index (paddr[ADDR_W-1:2])
   localparam logic REG_CAPACITY = 1'b0;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_POS   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REM_POS   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_LIST_FWD  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_LIST_BWD  = 3'd7;

   // status codes
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0]   name_tag;
      logic [TAG_W-1:0]   surname_tag;
      logic [GRADE_W-1:0] grade_math;
      logic [GRADE_W-1:0] grade_info;
      logic [GRADE_W-1:0] average;
   } record_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_ROT_L,
      OP_ROT_R
   } chain_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      chain_op_type     op;
      logic [CNT_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
   } chain_ctl_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] count;
      record_type       rec;
      logic             last;
   } rsp_type;

endpackage

// File: rtl/bprl_ifs.sv
// Channel interfaces: command items in, result items out
interface bprl_req_if
   import bprl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [POS_W-1:0]   position;
   logic [TAG_W-1:0]   name_tag;
   logic [TAG_W-1:0]   surname_tag;
   logic [GRADE_W-1:0] grade_math;
   logic [GRADE_W-1:0] grade_info;

   modport source (output valid, cmd, position, name_tag, surname_tag, grade_math,
                   grade_info, input ready);
   modport sink (input valid, cmd, position, name_tag, surname_tag, grade_math,
                 grade_info, output ready);
endinterface

interface bprl_rsp_if
   import bprl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [ST_W-1:0]    status;
   logic [CNT_W-1:0]   count;
   logic [TAG_W-1:0]   out_name_tag;
   logic [TAG_W-1:0]   out_surname_tag;
   logic [GRADE_W-1:0] out_grade_math;
   logic [GRADE_W-1:0] out_grade_info;
   logic [GRADE_W-1:0] average;
   logic               last;

   modport source (output valid, status, count, out_name_tag, out_surname_tag,
                   out_grade_math, out_grade_info, average, last, input ready);
   modport sink (input valid, status, count, out_name_tag, out_surname_tag,
                 out_grade_math, out_grade_info, average, last, output ready);
endinterface

// File: rtl/bprl_cell.sv
// One cell of the record chain: holds one record, loads from its neighbors, the new record or the wrap record
module bprl_cell
   import bprl_pkg::*;
#(
   parameter int Index = 0
) (
   input  logic          clock,
   input  chain_ctl_type ctl,
   input  record_type    prev_rec,
   input  record_type    next_rec,
   input  record_type    new_rec,
   input  record_type    wrap_rec,
   output record_type    rec
);

   record_type rec_ff, rec_in;
   int         idx_i, cnt_i;

   always_comb begin
      idx_i  = int'(ctl.idx);
      cnt_i  = int'(ctl.cnt);
      rec_in = rec_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (Index == idx_i) begin
               rec_in = new_rec;
            end else if (Index > idx_i && Index <= cnt_i) begin
               rec_in = prev_rec;
            end
         end
         OP_REMOVE: begin
            if (Index >= idx_i && Index < cnt_i - 1) begin
               rec_in = next_rec;
            end
         end
         OP_ROT_L: begin
            if (Index < cnt_i - 1) begin
               rec_in = next_rec;
            end else if (Index == cnt_i - 1) begin
               rec_in = wrap_rec;
            end
         end
         OP_ROT_R: begin
            if (Index == 0) begin
               rec_in = wrap_rec;
            end else if (Index < cnt_i) begin
               rec_in = prev_rec;
            end
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

// File: rtl/bounded_positional_record_list.sv
// Top level of the bounded positional record list
//
// Commands come in on req_chan, results leave on rsp_chan (valid/ready).
// Add and remove commands give one result with status, new count and
// zeroed record fields, in the cycle after the item is taken. List
// commands give one result per held record, one per cycle while rsp_chan
// does not stall; the state register first enters the listing state, then
// the result register loads the first record. The last is marked by last;
// an empty list gives a single empty-status result. The records sit in a
// chain of cells; an insert or remove shifts the tail and a listing rotates
// the chain once per result, leaving it as it was. A command is taken only
// when the block has no listing running and the result register is free or
// being drained.
// A stall on rsp_chan holds the result and pauses a listing in place.
// Reset empties the list and sets capacity to 16; record contents are not
// cleared. Capacity is written over the APB port at address 0.
module bounded_positional_record_list
   import bprl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bprl_req_if.sink          req_chan,
   bprl_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CAP_LIM = (DEPTH < MAX_REC) ? DEPTH : MAX_REC;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             dir_ff, dir_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CAP_W-1:0] eff_cap;
   logic             advance, accept, csr_write;
   logic             full, empty, pos_ok;
   logic [IDX_W-1:0] tail_idx;
   record_type       new_rec, list_rec;
   record_type       cells [DEPTH];
   record_type       prev_rec [DEPTH];
   record_type       next_rec [DEPTH];
   chain_ctl_type    ctl;
   logic [GRADE_W:0] grade_sum;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CAPACITY);
   assign prdata    = (paddr[ADDR_W-1:2] == REG_CAPACITY) ?
                      {{(DATA_W-CAP_W){1'b0}}, cap_ff} : '0;
   assign cap_in    = csr_write ? pwdata[CAP_W-1:0] : cap_ff;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > CAP_W'(CAP_LIM)) begin
         eff_cap = CAP_W'(CAP_LIM);
      end else begin
         eff_cap = cap_ff;
      end
   end

   // incoming record
   assign grade_sum           = {1'b0, req_chan.grade_math} + {1'b0, req_chan.grade_info};
   assign new_rec.name_tag    = req_chan.name_tag;
   assign new_rec.surname_tag = req_chan.surname_tag;
   assign new_rec.grade_math  = req_chan.grade_math;
   assign new_rec.grade_info  = req_chan.grade_info;
   assign new_rec.average     = grade_sum[GRADE_W:1];

   assign full   = count_ff >= eff_cap;
   assign empty  = count_ff == '0;
   assign pos_ok = (req_chan.position >= POS_W'(2)) &&
                   ({1'b0, req_chan.position} + 6'd1 <= {1'b0, count_ff});

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));
   assign list_rec = dir_ff ? cells[tail_idx] : cells[0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      dir_in       = dir_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ctl.op       = OP_HOLD;
      ctl.idx      = '0;
      ctl.cnt      = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.rec    = '0;
               rsp_in.last   = 1'b1;
               unique case (req_chan.cmd)
                  CMD_ADD_FRONT, CMD_ADD_BACK, CMD_ADD_POS: begin
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else if (req_chan.cmd == CMD_ADD_POS && !pos_ok) begin
                        rsp_in.status = ST_BADPOS;
                     end else begin
                        ctl.op   = OP_INSERT;
                        count_in = count_ff + CNT_W'(1);
                        if (req_chan.cmd == CMD_ADD_BACK) begin
                           ctl.idx = count_ff;
                        end else if (req_chan.cmd == CMD_ADD_POS) begin
                           ctl.idx = req_chan.position - POS_W'(1);
                        end
                     end
                  end
                  CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_POS: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (req_chan.cmd == CMD_REM_POS && !pos_ok) begin
                        rsp_in.status = ST_BADPOS;
                     end else begin
                        ctl.op   = OP_REMOVE;
                        count_in = count_ff - CNT_W'(1);
                        if (req_chan.cmd == CMD_REM_BACK) begin
                           ctl.idx = count_ff - CNT_W'(1);
                        end else if (req_chan.cmd == CMD_REM_POS) begin
                           ctl.idx = req_chan.position - POS_W'(1);
                        end
                     end
                  end
                  default: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        // results come from the listing loop
                        rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                        rsp_in       = rsp_ff;
                        state_in     = S_LIST;
                        left_in      = count_ff;
                        dir_in       = (req_chan.cmd == CMD_LIST_BWD);
                     end
                  end
               endcase
               if (rsp_valid_in) begin
                  rsp_in.count = count_in;
               end
            end
         end
         S_LIST: begin
            if (advance) begin
               // emit the head (or tail) and rotate it to the other end
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.count  = count_ff;
               rsp_in.rec    = list_rec;
               rsp_in.last   = (left_ff == CNT_W'(1));
               ctl.op        = dir_ff ? OP_ROT_R : OP_ROT_L;
               left_in       = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         left_ff      <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // chain of record cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_rec[g] = '0;
      end else begin : g_body
         assign prev_rec[g] = cells[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign next_rec[g] = '0;
      end else begin : g_mid
         assign next_rec[g] = cells[g+1];
      end

      bprl_cell #(
         .Index (g)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .prev_rec (prev_rec[g]),
         .next_rec (next_rec[g]),
         .new_rec  (new_rec),
         .wrap_rec (list_rec),
         .rec      (cells[g])
      );
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.count           = rsp_ff.count;
   assign rsp_chan.out_name_tag    = rsp_ff.rec.name_tag;
   assign rsp_chan.out_surname_tag = rsp_ff.rec.surname_tag;
   assign rsp_chan.out_grade_math  = rsp_ff.rec.grade_math;
   assign rsp_chan.out_grade_info  = rsp_ff.rec.grade_info;
   assign rsp_chan.average         = rsp_ff.rec.average;
   assign rsp_chan.last            = rsp_ff.last;

endmodule

// File: rtl/bprl_chk.sv
// Port checker for the record list, bound to the top level
`include "assert_macros.svh"

module bprl_chk
   import bprl_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [ST_W-1:0]    rsp_status,
   input logic [CNT_W-1:0]   rsp_count,
   input logic [TAG_W-1:0]   rsp_name_tag,
   input logic [GRADE_W-1:0] rsp_average,
   input logic               rsp_last
);

   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_count) && $stable(rsp_name_tag) && $stable(rsp_average) &&
      $stable(rsp_last), "stalled result item changed")

   `ASSERT_CLK(a_err_single, clock, reset,
      rsp_valid && rsp_status != ST_OK |-> rsp_last,
      "error result item not marked last")

   `ASSERT_CLK(a_no_cmd_in_list, clock, reset,
      rsp_valid && !rsp_last |-> !req_ready,
      "command taken while a listing runs")

   `ASSERT_CLK(a_count_bound, clock, reset,
      rsp_valid |-> rsp_count <= CNT_W'(MAX_REC),
      "record count above limit")

endmodule

bind bounded_positional_record_list bprl_chk u_bprl_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_count    (rsp_chan.count),
   .rsp_name_tag (rsp_chan.out_name_tag),
   .rsp_average  (rsp_chan.average),
   .rsp_last     (rsp_chan.last)
);
